// ----- rtl/gsp_pkg.sv -----
// Shared types and codes for the gain-scheduled PID step core.
// Used by gain_scheduled_pid_step_core; no dependencies.
package gsp_pkg;

    localparam int CfgWidth    = 48;
    localparam int CfgIdxWidth = 3;

    typedef enum logic [1:0] {
        ACT_LINE  = 2'd0,
        ACT_SCHED = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        BAND_LINE = 2'd0,
        BAND_LOW  = 2'd1,
        BAND_HIGH = 2'd2,
        BAND_OFF  = 2'd3
    } t_band;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_GAINS_LINE = 3'd0,
        REG_GAINS_LOW  = 3'd1,
        REG_GAINS_HIGH = 3'd2,
        REG_VEL_LOW    = 3'd3,
        REG_VEL_HIGH   = 3'd4
    } t_reg_idx;

    // Packed Q8.8 gain set: kd in the top bits, kp in the bottom bits.
    typedef struct packed {
        logic signed [15:0] kd;
        logic signed [15:0] ki;
        logic signed [15:0] kp;
    } t_gains;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] error_sample;
        logic [15:0]        set_speed;
    } t_in;

    typedef struct packed {
        logic signed [31:0] drive;
        logic [1:0]         band_used;
        logic               saturated;
    } t_out;

endpackage

// ----- rtl/gain_scheduled_pid_step_core.sv -----
// Gain-scheduled PID step with a saturating trapezoidal integral.
// Depends on gsp_pkg for payload structs, gain layout and codes.

// One transaction in, one result out, one transaction per clock sustained.
// In the pipeline, the first stage picks the gain set and updates the
// saturating integral and previous error (this loop closes inside stage one,
// so back-to-back errors see the updated state), stage two forms the three
// products, and the third sums, shifts right by eight with floor rounding and
// clamps to 32 bits into the output register. The pipeline only holds when the
// output register is full and stalled. Clear transactions zero the integral
// and return a zero result; action code 3 changes nothing and returns zeros.
// User must write configuration via a simple write port only while idle; no guard.
module gain_scheduled_pid_step_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gsp_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [gsp_pkg::CfgWidth-1:0]     i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  gsp_pkg::t_in                     i_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output gsp_pkg::t_out                    o_out
);
    import gsp_pkg::*;

    // configuration
    t_gains      r_gains_line, r_gains_low, r_gains_high;
    logic [15:0] r_vel_low, r_vel_high;

    // controller state
    logic signed [15:0] r_prev_err;
    logic               r_prev_valid;
    logic signed [31:0] r_int;

    // stage 1
    logic               r_s1_valid, r_s1_step, r_s1_hit;
    logic [1:0]         r_s1_band;
    t_gains             r_s1_gains;
    logic signed [15:0] r_s1_e;
    logic signed [16:0] r_s1_diff;
    logic signed [31:0] r_s1_ival;

    // stage 2
    logic               r_s2_valid, r_s2_step, r_s2_hit;
    logic [1:0]         r_s2_band;
    logic signed [31:0] r_s2_pkp;
    logic signed [32:0] r_s2_pkd;
    logic signed [47:0] r_s2_pki;

    // output
    logic r_ovalid;
    t_out r_out;

    logic rdy1, rdy2, rdy3, in_acc;

    assign rdy3    = !r_ovalid || !i_stall;
    assign rdy2    = !r_s2_valid || rdy3;
    assign rdy1    = !r_s1_valid || rdy2;
    assign o_stall = !rdy1;
    assign in_acc  = i_valid && rdy1;
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    // ---- stage 1: gain select, trapezoid integral ----
    logic               is_step, is_clear;
    t_gains             n_gains;
    logic [1:0]         n_band;
    logic signed [15:0] e, prev, incr;
    logic signed [16:0] pair_sum, n_diff;
    logic signed [32:0] isum;
    logic signed [31:0] n_ival;
    logic               n_ihit;

    always_comb begin
        e        = i_in.error_sample;
        is_step  = (i_in.action == ACT_LINE) || (i_in.action == ACT_SCHED);
        is_clear = (i_in.action == ACT_CLEAR);
        if (i_in.action == ACT_LINE) begin
            n_gains = r_gains_line;
            n_band  = BAND_LINE;
        end else if (i_in.set_speed < r_vel_low) begin
            n_gains = r_gains_low;
            n_band  = BAND_LOW;
        end else if (i_in.set_speed < r_vel_high) begin
            n_gains = r_gains_high;
            n_band  = BAND_HIGH;
        end else begin
            n_gains = '0;
            n_band  = BAND_OFF;
        end
        prev     = r_prev_valid ? r_prev_err : e;
        pair_sum = 17'(e) + 17'(prev);
        incr     = pair_sum[16:1];  // floor of half
        n_diff   = 17'(e) - 17'(prev);
        isum     = 33'(r_int) + 33'(incr);
        n_ihit   = (isum[32] != isum[31]);
        if (!n_ihit) begin
            n_ival = isum[31:0];
        end else if (isum[32]) begin
            n_ival = {1'b1, 31'd0};
        end else begin
            n_ival = {1'b0, {31{1'b1}}};
        end
    end

    // ---- stage 3: sum, floor shift, clamp ----
    logic signed [49:0] sum;
    logic signed [31:0] n_drive;
    logic               n_dhit;

    always_comb begin
        sum    = 50'(r_s2_pkp) + 50'(r_s2_pkd) + 50'(r_s2_pki);
        // sum >>> 8 fits 32 bits when bits 49..39 all agree
        n_dhit = !((&sum[49:39]) || !(|sum[49:39]));
        if (!n_dhit) begin
            n_drive = sum[39:8];
        end else if (sum[49]) begin
            n_drive = {1'b1, 31'd0};
        end else begin
            n_drive = {1'b0, {31{1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains_line <= '0;
            r_gains_low  <= '0;
            r_gains_high <= '0;
            r_vel_low    <= '0;
            r_vel_high   <= '0;
            r_prev_err   <= '0;
            r_prev_valid <= 1'b0;
            r_int        <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAINS_LINE: r_gains_line <= i_cfg_wdata;
                    REG_GAINS_LOW:  r_gains_low  <= i_cfg_wdata;
                    REG_GAINS_HIGH: r_gains_high <= i_cfg_wdata;
                    REG_VEL_LOW:    r_vel_low    <= i_cfg_wdata[15:0];
                    REG_VEL_HIGH:   r_vel_high   <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (in_acc && is_step) begin
                r_int        <= n_ival;
                r_prev_err   <= e;
                r_prev_valid <= 1'b1;
            end else if (in_acc && is_clear) begin
                r_int <= '0;
            end
            if (rdy1) begin
                r_s1_valid <= in_acc;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy3) begin
                r_ovalid <= r_s2_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_step  <= is_step;
            r_s1_hit   <= n_ihit;
            r_s1_band  <= n_band;
            r_s1_gains <= n_gains;
            r_s1_e     <= e;
            r_s1_diff  <= n_diff;
            r_s1_ival  <= n_ival;
        end
        if (rdy2) begin
            r_s2_step <= r_s1_step;
            r_s2_hit  <= r_s1_hit;
            r_s2_band <= r_s1_band;
            r_s2_pkp  <= 32'(r_s1_gains.kp) * 32'(r_s1_e);
            r_s2_pkd  <= 33'(r_s1_gains.kd) * 33'(r_s1_diff);
            r_s2_pki  <= 48'(r_s1_gains.ki) * 48'(r_s1_ival);
        end
        if (rdy3) begin
            if (r_s2_step) begin
                r_out.drive     <= n_drive;
                r_out.band_used <= r_s2_band;
                r_out.saturated <= r_s2_hit || n_dhit;
            end else begin
                // clear or unused action: zero result
                r_out <= '0;
            end
        end
    end

endmodule

// ----- dv/gain_scheduled_pid_step_core_tb.sv -----
// Self-checking testbench for gain_scheduled_pid_step_core: directed table and random
// phases, scored against an in-bench PID step predictor or a row's known result.
// Depends on gsp_pkg and the core RTL only.
module gain_scheduled_pid_step_core_tb;
    import gsp_pkg::*;

    localparam logic [CfgIdxWidth-1:0] SpareIdxLo = 3'd5;
    localparam logic [CfgIdxWidth-1:0] SpareIdxHi = 3'd7;
    localparam longint Int32Max = 64'sd2147483647;
    localparam longint Int32Min = -64'sd2147483648;
    localparam int HoldCycles = 48;

    typedef struct {
        t_action            act;
        logic signed [15:0] err;
        logic [15:0]        vel;
        bit                 has_result;
        logic signed [31:0] drive;
        t_band              band;
        bit                 sat;
    } t_directed_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] i_cfg_idx = '0;
    logic [CfgWidth-1:0]    i_cfg_wdata = '0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    t_in                    i_in = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    t_out                   o_out;

    // predictor copy of the configuration and loop state
    t_gains             gains_line = '0;
    t_gains             gains_low = '0;
    t_gains             gains_high = '0;
    logic [15:0]        vel_low = '0;
    logic [15:0]        vel_high = '0;
    logic signed [15:0] last_error = '0;
    bit                 last_error_valid = 1'b0;
    longint             integral = 0;

    t_out pending_outputs [$];
    int   mismatches = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_requests = 0;
    int   hold_grants = 0;
    int   hold_left = 0;

    gain_scheduled_pid_step_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint clamp32(longint x, inout bit hit);
        if (x > Int32Max) begin
            hit = 1'b1;
            return Int32Max;
        end
        if (x < Int32Min) begin
            hit = 1'b1;
            return Int32Min;
        end
        return x;
    endfunction

    function automatic t_out pid_step_predict(t_in it);
        t_out   res;
        t_gains g;
        longint err;
        longint prev;
        longint sum;
        bit     hit;
        res = '0;
        g = '0;
        hit = 1'b0;
        if (it.action == ACT_CLEAR) integral = 0;
        if (it.action == ACT_CLEAR || it.action == ACT_NONE) return res;
        if (it.action == ACT_LINE) begin
            g = gains_line;
            res.band_used = BAND_LINE;
        end else if (it.set_speed < vel_low) begin
            g = gains_low;
            res.band_used = BAND_LOW;
        end else if (it.set_speed < vel_high) begin
            g = gains_high;
            res.band_used = BAND_HIGH;
        end else begin
            res.band_used = BAND_OFF;
        end
        err = longint'(it.error_sample);
        // first step after reset: no derivative kick
        prev = last_error_valid ? longint'(last_error) : err;
        integral = clamp32(integral + ((err + prev) >>> 1), hit);
        sum = longint'(g.kp) * err + longint'(g.kd) * (err - prev)
            + longint'(g.ki) * integral;
        res.drive = 32'(clamp32(sum >>> 8, hit));
        res.saturated = hit;
        last_error = it.error_sample;
        last_error_valid = 1'b1;
        return res;
    endfunction

    function automatic logic signed [15:0] rand_gain_field();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'sh0100;
            4: return 16'($urandom_range(1023)) - 16'sd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_gains rand_gains();
        t_gains g;
        g.kp = rand_gain_field();
        g.ki = rand_gain_field();
        g.kd = rand_gain_field();
        return g;
    endfunction

    function automatic logic [15:0] rand_limit();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_grants != hold_requests) begin
            hold_grants <= hold_requests;
            hold_left <= HoldCycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (o_valid && !i_stall) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: drive %0d band %0d sat %0b",
                             o_out.drive, o_out.band_used, o_out.saturated);
            end else begin
                want = pending_outputs.pop_front();
                if (o_out.drive !== want.drive || o_out.band_used !== want.band_used ||
                    o_out.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp drive %0d band %0d sat %0b, got %0d %0d %0b",
                                 want.drive, want.band_used, want.saturated,
                                 o_out.drive, o_out.band_used, o_out.saturated);
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send(t_in it, bit use_known, t_out known);
        t_out pred;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = pid_step_predict(it);
        pending_outputs.push_back(use_known ? known : pred);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every result is back.
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_outputs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
    endtask

    task automatic load_config(t_gains line_g, t_gains low_g, t_gains high_g,
                               logic [15:0] v_lo, logic [15:0] v_hi);
        drain();
        // unmapped index must be ignored
        cfg_write(3'($urandom_range(SpareIdxHi, SpareIdxLo)), {16'($urandom), 32'($urandom)});
        cfg_write(REG_GAINS_LINE, line_g);
        cfg_write(REG_GAINS_LOW, low_g);
        cfg_write(REG_GAINS_HIGH, high_g);
        // junk in the upper bits must be masked off
        cfg_write(REG_VEL_LOW, {32'($urandom), v_lo});
        cfg_write(REG_VEL_HIGH, {32'($urandom), v_hi});
        i_cfg_we <= 1'b0;
        gains_line = line_g;
        gains_low = low_g;
        gains_high = high_g;
        vel_low = v_lo;
        vel_high = v_hi;
    endtask

    task automatic run_random(int count, int pause_at, int hold_at);
        t_in it;
        int  pick;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_requests++;
            if (n == pause_at) drain();
            pick = $urandom_range(99);
            it.action = pick < 45 ? ACT_LINE : pick < 88 ? ACT_SCHED :
                        pick < 97 ? ACT_CLEAR : ACT_NONE;
            case ($urandom_range(3))
                0: it.error_sample = 16'($urandom);
                1: it.error_sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                default: it.error_sample = 16'($urandom_range(4000)) - 16'sd2000;
            endcase
            // land near the band edges often
            case ($urandom_range(2))
                0: it.set_speed = 16'($urandom);
                1: it.set_speed = 16'(vel_low + $urandom_range(2) - 1);
                default: it.set_speed = 16'(vel_high + $urandom_range(2) - 1);
            endcase
            send(it, 1'b0, '0);
        end
    endtask

    initial begin
        t_directed_row rows [21];
        t_in           it;
        t_out          known;
        // line gains are kp = 1.0 only, so a line step returns the error itself
        rows = '{
            '{ACT_LINE,  16'sd100,  16'd0,     1'b1, 32'sd100,    BAND_LINE, 1'b0},
            '{ACT_LINE,  16'sh8000, 16'd0,     1'b1, -32'sd32768, BAND_LINE, 1'b0},
            '{ACT_LINE,  16'sh7FFF, 16'd0,     1'b1, 32'sd32767,  BAND_LINE, 1'b0},
            '{ACT_LINE,  16'sd0,    16'd65535, 1'b1, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_CLEAR, 16'sd123,  16'd0,     1'b1, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_NONE,  -16'sd1,   16'd65535, 1'b1, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, 16'sh7FFF, 16'd0,     1'b0, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, 16'sh8000, 16'd999,   1'b0, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, 16'sd1,    16'd1000,  1'b0, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, -16'sd1,   16'd49999, 1'b0, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, 16'sh7FFF, 16'd50000, 1'b1, 32'sd0,      BAND_OFF,  1'b0},
            '{ACT_SCHED, 16'sh8000, 16'd65535, 1'b1, 32'sd0,      BAND_OFF,  1'b0},
            '{ACT_SCHED, 16'sd0,    16'd65535, 1'b1, 32'sd0,      BAND_OFF,  1'b0},
            '{ACT_CLEAR, 16'sh7FFF, 16'd1000,  1'b1, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, 16'sh7FFF, 16'd0,     1'b0, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, 16'sh8000, 16'd0,     1'b0, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, 16'sh8000, 16'd1000,  1'b0, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_SCHED, 16'sh7FFF, 16'd1000,  1'b0, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_LINE,  16'sd5,    16'd0,     1'b1, 32'sd5,      BAND_LINE, 1'b0},
            '{ACT_NONE,  16'sh7FFF, 16'd0,     1'b1, 32'sd0,      BAND_LINE, 1'b0},
            '{ACT_LINE,  -16'sd5,   16'd65535, 1'b1, -32'sd5,     BAND_LINE, 1'b0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // gain words are {kd, ki, kp}
        load_config(48'h0000_0000_0100, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
                    16'd1000, 16'd50000);
        foreach (rows[k]) begin
            it.action = rows[k].act;
            it.error_sample = rows[k].err;
            it.set_speed = rows[k].vel;
            known.drive = rows[k].drive;
            known.band_used = rows[k].band;
            known.saturated = rows[k].sat;
            send(it, rows[k].has_result, known);
        end

        load_config(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                    16'hFFFF, 16'hFFFF);
        run_random(200, -1, 80);

        load_config(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                    16'd0, 16'hFFFF);
        idle_pct = 88;
        run_random(200, 100, -1);

        load_config(rand_gains(), rand_gains(), rand_gains(), rand_limit(), rand_limit());
        idle_pct = 0;
        stall_pct = 88;
        run_random(200, -1, -1);

        load_config(rand_gains(), rand_gains(), rand_gains(), rand_limit(), rand_limit());
        idle_pct = 21;
        stall_pct = 21;
        run_random(200, 120, 60);

        drain();
        if (mismatches == 0 && pending_outputs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
